>>> src/sws_pkg.sv
// Shared types and constants for the stopwatch with debounced start button.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package sws_pkg;

    // Configuration register indexes.
    localparam logic [7:0] REG_TICKS_PER_SECOND = 8'd0;
    localparam logic [7:0] REG_DEBOUNCE_TICKS   = 8'd1;
    localparam logic [7:0] REG_BEEP_TICKS       = 8'd2;
    localparam logic [7:0] REG_BLINK_TICKS      = 8'd3;

    // Reset values of the configuration registers.
    localparam logic [15:0] TICKS_PER_SECOND_RST = 16'd1000;
    localparam logic [7:0]  DEBOUNCE_TICKS_RST   = 8'd20;
    localparam logic [7:0]  BEEP_TICKS_RST       = 8'd100;
    localparam logic [7:0]  BLINK_TICKS_RST      = 8'd200;

    // Mode codes.
    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_RUNNING = 2'd1;
    localparam logic [1:0] MODE_PENDING = 2'd2;
    localparam logic [1:0] MODE_STOPPED = 2'd3;

    // Active-low code with every segment dark.
    localparam logic [7:0] SEG_OFF = 8'hFF;

    // Debouncer state.
    typedef struct packed {
        logic       raw;
        logic [7:0] quiet;
        logic       stable;
    } deb_state_t;

    // Active-low seven-segment code of one decimal digit.
    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] code;
        unique case (digit)
            4'd0:    code = 8'hA0;
            4'd1:    code = 8'hF9;
            4'd2:    code = 8'h64;
            4'd3:    code = 8'h70;
            4'd4:    code = 8'h2D;
            4'd5:    code = 8'h32;
            4'd6:    code = 8'h22;
            4'd7:    code = 8'hF8;
            4'd8:    code = 8'h20;
            4'd9:    code = 8'h38;
            default: code = SEG_OFF;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

>>> src/sws_debounce.sv
// Next-state logic of the start-button debouncer for one tick.
// Depends on sws_pkg for the debouncer state type.
`default_nettype none

module sws_debounce (
    input  wire sws_pkg::deb_state_t state,
    input  wire                      sample,
    input  wire [7:0]                debounce_ticks,
    output sws_pkg::deb_state_t      state_next,
    output logic                     pressed
);
    import sws_pkg::*;

    always_comb
    begin
        state_next = state;
        pressed    = 1'b0;
        priority if (sample != state.raw)
        begin
            // Any change of the raw level restarts the quiet period.
            state_next.raw   = sample;
            state_next.quiet = debounce_ticks;
        end
        else if (state.quiet != 8'd0)
        begin
            state_next.quiet = state.quiet - 8'd1;
        end
        else if (state.raw != state.stable)
        begin
            state_next.stable = state.raw;
            pressed           = state.raw;
        end
    end

endmodule

`default_nettype wire

>>> src/sws_digits.sv
// Splits an 8-bit count into its last two decimal digits and encodes both.
// Depends on sws_pkg for the segment table.
`default_nettype none

module sws_digits (
    input  wire [7:0]  value,
    output logic [7:0] tens_code,
    output logic [7:0] ones_code
);
    import sws_pkg::*;

    logic [7:0]  below_200;
    logic [6:0]  below_100;
    logic [14:0] scaled;
    logic [3:0]  tens;
    logic [6:0]  tens_times_ten;
    logic [3:0]  ones;

    always_comb
    begin
        below_200 = (value >= 8'd200) ? value - 8'd200 : value;
        below_100 = (below_200 >= 8'd100) ? 7'(below_200 - 8'd100) : below_200[6:0];
        // Divide by ten through the reciprocal 205/2048, exact below 100.
        scaled         = 15'(below_100) * 15'd205;
        tens           = scaled[14:11];
        tens_times_ten = 7'(tens) * 7'd10;
        ones           = 4'(below_100 - tens_times_ten);
        tens_code      = seg_code(tens);
        ones_code      = seg_code(ones);
    end

endmodule

`default_nettype wire

>>> src/stopwatch_with_debounce_top.sv
// Top level of the stopwatch controller with debounced start button.
// Depends on sws_pkg, sws_debounce and sws_digits.
`default_nettype none

// Each input word is one millisecond tick carrying the raw start-button
// level; each tick yields exactly one result word holding the two
// active-low digit codes, the blank flag, the beeper enable and the mode.
// A word is taken into an input register; once the result slot is free,
// all counters, the debouncer, the mode step and the display update are
// worked out in one pass and written to the state registers, which drive
// the result ports directly. One word is accepted every cycle while
// results are taken; a result that is not taken holds up both the
// input register and the input channel. The pass through
// the seconds compare, the debouncer, the mode step and the decimal split
// sets the clock period. A press walks the mode from idle to running
// (seconds are taken as the start and a beep begins), from running to
// stopped (another beep, the display then blinks) and from stopped back
// to idle (both digits go dark). The configuration registers are written
// through their own channel, which is always ready; writes to indexes
// beyond the four registers are taken and ignored. Write them only while
// no tick is in flight.

module stopwatch_with_debounce_top (
    input  wire         clk,
    input  wire         rst_n,
    // Tick channel.
    input  wire         in_valid,
    output logic        in_ready,
    input  wire         button_level,
    // Result channel.
    output logic        out_valid,
    input  wire         out_ready,
    output logic [7:0]  tens_segments,
    output logic [7:0]  ones_segments,
    output logic        display_blank,
    output logic        beeper_on,
    output logic [1:0]  run_mode,
    // Configuration channel.
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire [7:0]   cfg_index,
    input  wire [15:0]  cfg_data
);
    import sws_pkg::*;

    // Configuration registers.
    logic [15:0] ticks_per_second_reg;
    logic [7:0]  debounce_ticks_reg;
    logic [7:0]  beep_ticks_reg;
    logic [7:0]  blink_ticks_reg;

    // Input stage.
    logic        in_valid_reg;
    logic        level_reg;

    // Block state; it also forms the result word.
    logic        out_valid_reg;
    logic [7:0]  ms_reg,       ms_next;
    logic [15:0] sub_reg,      sub_next;
    logic [7:0]  sec_reg,      sec_next;
    logic [7:0]  beep_reg,     beep_next;
    deb_state_t  deb_reg,      deb_next;
    logic [1:0]  mode_reg,     mode_next;
    logic [7:0]  start_reg,    start_next;
    logic [7:0]  shown_reg,    shown_next;
    logic [7:0]  mark_reg,     mark_next;
    logic        blank_reg,    blank_next;
    logic [7:0]  tens_reg,     tens_next;
    logic [7:0]  ones_reg,     ones_next;

    logic        stage_free;
    logic        advance;
    logic        pressed;
    logic [15:0] sub_inc;
    logic [7:0]  elapsed;
    logic [7:0]  elapsed_tens;
    logic [7:0]  elapsed_ones;

    // The processing pass may run when the result slot is empty or is
    // being emptied in this cycle.
    assign stage_free = !out_valid_reg || out_ready;
    assign advance    = in_valid_reg && stage_free;
    assign in_ready   = !in_valid_reg || stage_free;
    assign cfg_ready  = 1'b1;

    assign out_valid     = out_valid_reg;
    assign tens_segments = tens_reg;
    assign ones_segments = ones_reg;
    assign display_blank = blank_reg;
    assign beeper_on     = (beep_reg != 8'd0);
    assign run_mode      = mode_reg;

    sws_debounce u_debounce (
        .state          (deb_reg),
        .sample         (level_reg),
        .debounce_ticks (debounce_ticks_reg),
        .state_next     (deb_next),
        .pressed        (pressed)
    );

    sws_digits u_digits (
        .value     (elapsed),
        .tens_code (elapsed_tens),
        .ones_code (elapsed_ones)
    );

    always_comb
    begin
        ms_next    = ms_reg + 8'd1;
        sub_inc    = sub_reg + 16'd1;
        sub_next   = sub_inc;
        sec_next   = sec_reg;
        beep_next  = (beep_reg != 8'd0) ? beep_reg - 8'd1 : beep_reg;
        mode_next  = mode_reg;
        start_next = start_reg;
        shown_next = shown_reg;
        mark_next  = mark_reg;
        blank_next = blank_reg;
        tens_next  = tens_reg;
        ones_next  = ones_reg;

        if (sub_inc >= ticks_per_second_reg)
        begin
            sub_next = 16'd0;
            sec_next = sec_reg + 8'd1;
        end

        // A debounced press steps the mode; a press in idle or running restarts
        // the beep.
        if (pressed)
        begin
            unique case (mode_reg)
                MODE_IDLE:
                begin
                    start_next = sec_next;
                    mode_next  = MODE_RUNNING;
                    beep_next  = beep_ticks_reg;
                end
                MODE_RUNNING:
                begin
                    mode_next = MODE_PENDING;
                    beep_next = beep_ticks_reg;
                end
                MODE_PENDING, MODE_STOPPED:
                begin
                    tens_next = SEG_OFF;
                    ones_next = SEG_OFF;
                    mode_next = MODE_IDLE;
                end
            endcase
        end

        elapsed = sec_next - start_next;

        // Display update for the mode reached in this tick.
        unique case (mode_next)
            MODE_RUNNING:
            begin
                if (elapsed != shown_reg)
                begin
                    shown_next = elapsed;
                    tens_next  = elapsed_tens;
                    ones_next  = elapsed_ones;
                    blank_next = 1'b0;
                end
            end
            MODE_PENDING:
            begin
                // The stop is settled within the same tick: freeze the
                // digits and start the blink period from now.
                shown_next = elapsed;
                tens_next  = elapsed_tens;
                ones_next  = elapsed_ones;
                blank_next = 1'b0;
                mode_next  = MODE_STOPPED;
                mark_next  = ms_next;
            end
            MODE_STOPPED:
            begin
                if (8'(ms_next - mark_reg) >= blink_ticks_reg)
                begin
                    mark_next  = mark_reg + blink_ticks_reg;
                    blank_next = !blank_reg;
                end
            end
            MODE_IDLE:
            begin
            end
        endcase
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_per_second_reg <= TICKS_PER_SECOND_RST;
            debounce_ticks_reg   <= DEBOUNCE_TICKS_RST;
            beep_ticks_reg       <= BEEP_TICKS_RST;
            blink_ticks_reg      <= BLINK_TICKS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_TICKS_PER_SECOND: ticks_per_second_reg <= cfg_data;
                REG_DEBOUNCE_TICKS:   debounce_ticks_reg   <= cfg_data[7:0];
                REG_BEEP_TICKS:       beep_ticks_reg       <= cfg_data[7:0];
                REG_BLINK_TICKS:      blink_ticks_reg      <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            level_reg <= button_level;
        end
    end

    // State and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            ms_reg        <= 8'd0;
            sub_reg       <= 16'd0;
            sec_reg       <= 8'd0;
            beep_reg      <= 8'd0;
            deb_reg       <= '0;
            mode_reg      <= MODE_IDLE;
            start_reg     <= 8'd0;
            shown_reg     <= 8'd0;
            mark_reg      <= 8'd0;
            blank_reg     <= 1'b0;
            tens_reg      <= SEG_OFF;
            ones_reg      <= SEG_OFF;
        end
        else
        begin
            if (stage_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance)
            begin
                ms_reg    <= ms_next;
                sub_reg   <= sub_next;
                sec_reg   <= sec_next;
                beep_reg  <= beep_next;
                deb_reg   <= deb_next;
                mode_reg  <= mode_next;
                start_reg <= start_next;
                shown_reg <= shown_next;
                mark_reg  <= mark_next;
                blank_reg <= blank_next;
                tens_reg  <= tens_next;
                ones_reg  <= ones_next;
            end
        end
    end

    // The stop-pending mode is resolved inside the pass and never stored.
    assert property (@(posedge clk) disable iff (!rst_n) mode_reg != MODE_PENDING)
        else $error("stop-pending mode was stored");

    // A start or stop press loads the beep countdown with the beep length.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && pressed && (mode_reg == MODE_IDLE || mode_reg == MODE_RUNNING))
        |=> beep_reg == $past(beep_ticks_reg))
        else $error("beep countdown not restarted on a press");

    // Returning to idle darkens both digits.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && mode_reg == MODE_STOPPED && mode_next == MODE_IDLE)
        |=> (tens_segments == SEG_OFF && ones_segments == SEG_OFF))
        else $error("digits not darkened on return to idle");

    // State only moves when a tick is processed.
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(ms_reg) && $stable(mode_reg))
        else $error("state changed without a tick");

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for stopwatch_with_debounce_top: drives tick words, predicts every
// result word with its own stopwatch model and compares them. Depends on sws_pkg and the RTL.

module tb;
    import sws_pkg::*;

    localparam int         CLK_PERIOD    = 8;
    localparam int         CYCLE_LIMIT   = 200000;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         MAX_REPORTS   = 10;
    // An index beyond the four registers; writes to it must be ignored.
    localparam logic [7:0] REG_UNUSED    = 8'hFC;

    typedef struct packed {
        logic [7:0] tens;
        logic [7:0] ones;
        logic       blank;
        logic       beep;
        logic [1:0] mode;
    } watch_word_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        button_level;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  tens_segments;
    logic [7:0]  ones_segments;
    logic        display_blank;
    logic        beeper_on;
    logic [1:0]  run_mode;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [15:0] cfg_data;

    stopwatch_with_debounce_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .button_level  (button_level),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .tens_segments (tens_segments),
        .ones_segments (ones_segments),
        .display_blank (display_blank),
        .beeper_on     (beeper_on),
        .run_mode      (run_mode),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Register copies held by the predictor.
    logic [15:0] w_tps;
    logic [7:0]  w_debounce;
    logic [7:0]  w_beep;
    logic [7:0]  w_blink;

    // Predicted stopwatch state.
    logic [7:0]  ms_count;
    logic [15:0] sub_ticks;
    logic [7:0]  sec_count;
    logic [7:0]  beep_left;
    logic        raw_level;
    logic [7:0]  quiet_left;
    logic        stable_level;
    logic [1:0]  watch_mode;
    logic [7:0]  start_sec;
    logic [7:0]  last_shown;
    logic [7:0]  blink_mark;
    logic        blank_flag;
    logic [7:0]  tens_code;
    logic [7:0]  ones_code;

    watch_word_t pending_words[$];
    int unsigned ticks_sent;
    int unsigned failures;
    int unsigned hold_cycles;
    bit          hold_results;
    bit          steady;

    function automatic logic [7:0] digit_segments(input int unsigned d);
        case (d)
            0:       return 8'hA0;
            1:       return 8'hF9;
            2:       return 8'h64;
            3:       return 8'h70;
            4:       return 8'h2D;
            5:       return 8'h32;
            6:       return 8'h22;
            7:       return 8'hF8;
            8:       return 8'h20;
            default: return 8'h38;
        endcase
    endfunction

    function automatic void reset_watch();
        w_tps        = TICKS_PER_SECOND_RST;
        w_debounce   = DEBOUNCE_TICKS_RST;
        w_beep       = BEEP_TICKS_RST;
        w_blink      = BLINK_TICKS_RST;
        ms_count     = '0;
        sub_ticks    = '0;
        sec_count    = '0;
        beep_left    = '0;
        raw_level    = 1'b0;
        quiet_left   = '0;
        stable_level = 1'b0;
        watch_mode   = MODE_IDLE;
        start_sec    = '0;
        last_shown   = '0;
        blink_mark   = '0;
        blank_flag   = 1'b0;
        tens_code    = SEG_OFF;
        ones_code    = SEG_OFF;
    endfunction

    function automatic void apply_register(input logic [7:0] idx, input logic [15:0] value);
        case (idx)
            REG_TICKS_PER_SECOND: w_tps      = value;
            REG_DEBOUNCE_TICKS:   w_debounce = value[7:0];
            REG_BEEP_TICKS:       w_beep     = value[7:0];
            REG_BLINK_TICKS:      w_blink    = value[7:0];
            default:              ;
        endcase
    endfunction

    // Elapsed seconds are shown modulo 100.
    function automatic void show_elapsed(input logic [7:0] secs);
        last_shown = secs;
        tens_code  = digit_segments((int'(secs) % 100) / 10);
        ones_code  = digit_segments(int'(secs) % 10);
        blank_flag = 1'b0;
    endfunction

    // One millisecond tick: counters, beep, seconds, debouncer, press, display.
    function automatic watch_word_t step_watch(input logic lvl);
        watch_word_t word;
        logic [7:0]  elapsed;
        logic        pressed;
        pressed   = 1'b0;
        ms_count  = ms_count + 8'd1;
        sub_ticks = sub_ticks + 16'd1;
        if (beep_left != 8'd0)
            beep_left = beep_left - 8'd1;
        if (sub_ticks >= w_tps)
        begin
            sub_ticks = '0;
            sec_count = sec_count + 8'd1;
        end

        if (lvl != raw_level)
        begin
            raw_level  = lvl;
            quiet_left = w_debounce;
        end
        else if (quiet_left != 8'd0)
            quiet_left = quiet_left - 8'd1;
        else if (raw_level != stable_level)
        begin
            stable_level = raw_level;
            pressed      = stable_level;
        end

        // Only a press steps the mode; an accepted release changes nothing.
        if (pressed)
        begin
            if (watch_mode == MODE_IDLE)
            begin
                start_sec  = sec_count;
                watch_mode = MODE_RUNNING;
                beep_left  = w_beep;
            end
            else if (watch_mode == MODE_RUNNING)
            begin
                watch_mode = MODE_PENDING;
                beep_left  = w_beep;
            end
            else
            begin
                tens_code  = SEG_OFF;
                ones_code  = SEG_OFF;
                watch_mode = MODE_IDLE;
            end
        end

        elapsed = sec_count - start_sec;
        if (watch_mode == MODE_RUNNING)
        begin
            if (elapsed != last_shown)
                show_elapsed(elapsed);
        end
        else if (watch_mode == MODE_PENDING)
        begin
            show_elapsed(elapsed);
            watch_mode = MODE_STOPPED;
            blink_mark = ms_count;
        end
        else if (watch_mode == MODE_STOPPED)
        begin
            if (8'(ms_count - blink_mark) >= w_blink)
            begin
                blink_mark = blink_mark + w_blink;
                blank_flag = !blank_flag;
            end
        end

        word.tens  = tens_code;
        word.ones  = ones_code;
        word.blank = blank_flag;
        word.beep  = (beep_left != 8'd0);
        word.mode  = watch_mode;
        return word;
    endfunction

    function automatic void check_word(input watch_word_t got);
        watch_word_t want;
        if (pending_words.size() == 0)
        begin
            failures++;
            if (failures <= MAX_REPORTS)
                $display("unexpected result word: tens %h ones %h blank %b beep %b mode %0d",
                         got.tens, got.ones, got.blank, got.beep, got.mode);
            return;
        end
        want = pending_words.pop_front();
        if (got.tens !== want.tens || got.ones !== want.ones || got.blank !== want.blank ||
            got.beep !== want.beep || got.mode !== want.mode)
        begin
            failures++;
            if (failures <= MAX_REPORTS)
                $display("word mismatch: expected tens %h ones %h blank %b beep %b mode %0d, %s",
                         want.tens, want.ones, want.blank, want.beep, want.mode,
                         $sformatf("got tens %h ones %h blank %b beep %b mode %0d",
                                   got.tens, got.ones, got.blank, got.beep, got.mode));
        end
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Handshakes are observed at the edge itself, so every process sees
    // the values that the block saw.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            pending_words.push_back(step_watch(button_level));
        if (rst_n && cfg_valid && cfg_ready)
            apply_register(cfg_index, cfg_data);
        if (rst_n && out_valid && out_ready)
            check_word({tens_segments, ones_segments, display_blank, beeper_on, run_mode});
    end

    // Receiver: random stalls, none while steady, and on request one long
    // hold-off so that the block fills up and stops taking words.
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_results)
            begin
                out_ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_results = 1'b0;
            end
            else
                out_ready <= steady || ($urandom_range(99) >= 15);
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("stopwatch_with_debounce_top regression: fail");
        $finish;
    end

    // Sends one tick word; ready is sampled at the falling edge so the
    // decision does not race with the rising edge.
    task automatic send_tick(input logic lvl);
        logic taken;
        while (!steady && $urandom_range(99) < 15)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        button_level <= lvl;
        do
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        while (!taken);
        ticks_sent++;
    endtask

    // Waits until every expected word has come back, then lets the
    // pipeline and any stalled output settle.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk);
        while (pending_words.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] value);
        logic taken;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic configure(input logic [15:0] tps, input logic [15:0] deb,
                             input logic [15:0] beep, input logic [15:0] blink);
        wait_drained();
        write_reg(REG_UNUSED, 16'($urandom));
        write_reg(REG_TICKS_PER_SECOND, tps);
        write_reg(REG_DEBOUNCE_TICKS, deb);
        write_reg(REG_BEEP_TICKS, beep);
        write_reg(REG_BLINK_TICKS, blink);
        cfg_valid <= 1'b0;
    endtask

    // A change of level with some contact bounce first, then held long
    // enough for the debouncer to accept it.
    task automatic settle_button(input logic lvl);
        int unsigned glitches;
        glitches = $urandom_range(3);
        repeat (glitches)
        begin
            repeat ($urandom_range(2, 1)) send_tick(lvl);
            repeat ($urandom_range(2, 1)) send_tick(!lvl);
        end
        repeat (int'(w_debounce) + 2 + $urandom_range(6)) send_tick(lvl);
    endtask

    // Mostly clean press-and-release sessions with a released gap, which
    // is now and then long enough for the seconds to pass 100 and 200;
    // the rest is raw noise on the button.
    task automatic run_sessions(input int unsigned n_ticks);
        int unsigned stop_at;
        stop_at = ticks_sent + n_ticks;
        while (ticks_sent < stop_at)
        begin
            if ($urandom_range(99) < 80)
            begin
                settle_button(1'b1);
                settle_button(1'b0);
                repeat (($urandom_range(99) < 15) ? $urandom_range(260, 100)
                                                  : $urandom_range(40))
                    send_tick(1'b0);
            end
            else
                repeat ($urandom_range(10, 1)) send_tick(1'($urandom_range(1)));
        end
    endtask

    // Reset values: digits dark, idle, and short bounces that the default
    // debounce time swallows.
    task automatic test_reset_values();
        logic [0:7] pattern;
        pattern = 8'b0010_1100;
        for (int i = 0; i < 8; i++)
            send_tick(pattern[i]);
    endtask

    // Hand-made walk through every mode: a start at the last shown value,
    // a release that changes nothing, a stop while still beeping, blinking
    // on every tick with a zero half period, a return to idle, then bounce.
    task automatic test_directed();
        logic [0:19] pattern;
        pattern = 20'b0111_0011_1100_1110_1010;
        configure(16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
        for (int i = 0; i < 20; i++)
            send_tick(pattern[i]);
    endtask

    // Seconds step on every tick, no debounce, no beep, fastest blink;
    // neither side idles here.
    task automatic test_fast_count();
        configure(16'h0001, 16'hFF00, 16'h0000, 16'h0001);
        steady = 1'b1;
        run_sessions(300);
        wait_drained();
        steady = 1'b0;
    endtask

    task automatic test_backpressure();
        configure(16'd3, 16'd2, 16'd7, 16'd3);
        hold_cycles  = 80;
        hold_results = 1'b1;
        run_sessions(250);
    endtask

    // Largest register values: a press needs hundreds of ticks.
    task automatic test_slow_extremes();
        configure(16'hFFFF, 16'h00FF, 16'h00FF, 16'hFFFF);
        run_sessions(300);
    endtask

    task automatic test_random_settings();
        repeat (2)
        begin
            configure(16'($urandom_range(6, 1)), 16'($urandom_range(5)),
                      16'($urandom_range(30)), 16'($urandom_range(12, 1)));
            run_sessions(300);
        end
    endtask

    initial
    begin
        reset_watch();
        ticks_sent   = 0;
        failures     = 0;
        hold_cycles  = 0;
        hold_results = 1'b0;
        steady       = 1'b0;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        button_level <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_values();
        test_directed();
        test_fast_count();
        test_backpressure();
        test_slow_extremes();
        test_random_settings();

        wait_drained();
        if (failures == 0)
            $display("stopwatch_with_debounce_top regression: pass");
        else
            $display("stopwatch_with_debounce_top regression: fail");
        $finish;
    end

endmodule

>>> sim.f
src/sws_pkg.sv
src/sws_debounce.sv
src/sws_digits.sv
src/stopwatch_with_debounce_top.sv
tb/tb.sv
